[sv/qtw_pkg.sv]
// Shared widths, constants, types and the arctangent table of the tilt weight unit.
`default_nettype none
package qtw_pkg;

  localparam int Q_W        = 16;
  localparam int ANG_W      = 16;
  localparam int SOFT_W     = 15;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int CW               = 36;   // CORDIC x/y datapath
  localparam int ZW               = 33;   // CORDIC angle accumulator, Q.30

  localparam int SQ_RAD_W  = 62;
  localparam int SQ_ROOT_W = 31;
  localparam int SQ_REM_W  = 35;

  localparam int M_W    = 15;   // angle magnitude
  localparam int DEN_W  = 16;   // soft angle plus magnitude
  localparam int WQ_W   = 17;   // raw weight quotient
  localparam int WT_W   = 16;

  localparam logic [SOFT_W-1:0] SOFT_ANGLE_RST = 15'd429;
  localparam logic [GAIN_W-1:0] TILT_GAIN_RST  = 16'd3086;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;

  // front stages, square root, finish, divider, weight and product stages
  localparam int FRONT_STAGES = 4;
  localparam int DIV_STAGES   = WQ_W;
  localparam int BACK_STAGES  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOFT_ANGLE = 2'd0,
    REG_TILT_GAIN  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] n;
    logic signed [CW-1:0] d;
    logic signed [CW-1:0] s;
  } sq_side_t;

  typedef struct packed {
    logic d_zero;
    logic n_pos;
    logic n_neg;
  } roll_flag_t;

  typedef struct packed {
    logic c_zero;
    logic s_pos;
  } pitch_flag_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] angle;
    logic [M_W-1:0]          mag;
  } ang_side_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0:  t = 33'sd843314856;
      1:  t = 33'sd497837829;
      2:  t = 33'sd263043836;
      3:  t = 33'sd133525158;
      4:  t = 33'sd67021686;
      5:  t = 33'sd33543515;
      6:  t = 33'sd16775850;
      7:  t = 33'sd8388437;
      8:  t = 33'sd4194282;
      9:  t = 33'sd2097149;
      10: t = 33'sd1048575;
      11: t = 33'sd524287;
      12: t = 33'sd262143;
      13: t = 33'sd131071;
      14: t = 33'sd65535;
      15: t = 33'sd32767;
      16: t = 33'sd16383;
      17: t = 33'sd8191;
      18: t = 33'sd4095;
      19: t = 33'sd2047;
      20: t = 33'sd1023;
      21: t = 33'sd511;
      22: t = 33'sd255;
      23: t = 33'sd127;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic int qtw_latency(input int steps);
    return FRONT_STAGES + SQ_ROOT_W + steps + 1 + DIV_STAGES + BACK_STAGES;
  endfunction

endpackage
`default_nettype wire

[sv/qtw_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module qtw_sqrt_pipe #(
  parameter int SIDE_W = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [qtw_pkg::SQ_RAD_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0]              in_side,
  output logic                           out_valid,
  output logic [qtw_pkg::SQ_ROOT_W-1:0]  out_root,
  output logic [SIDE_W-1:0]              out_side
);
  import qtw_pkg::*;

  localparam int NS = SQ_ROOT_W;

  logic                 vld_r  [NS];
  logic [SQ_RAD_W-1:0]  rad_r  [NS];
  logic [SQ_REM_W-1:0]  rem_r  [NS];
  logic [SQ_ROOT_W-1:0] root_r [NS];
  logic [SIDE_W-1:0]    side_r [NS];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      logic                 v_in;
      logic [SQ_RAD_W-1:0]  rad_in;
      logic [SQ_REM_W-1:0]  rem_in;
      logic [SQ_ROOT_W-1:0] root_in;
      logic [SIDE_W-1:0]    side_in;
      logic [SQ_REM_W-1:0]  rem_sh;
      logic [SQ_REM_W-1:0]  trial;
      logic                 fit;
      logic [SQ_REM_W-1:0]  rem_nxt;
      logic [SQ_ROOT_W-1:0] root_nxt;

      if (k == 0) begin : g_first
        assign v_in    = in_valid;
        assign rad_in  = in_rad;
        assign rem_in  = '0;
        assign root_in = '0;
        assign side_in = in_side;
      end else begin : g_next
        assign v_in    = vld_r[k-1];
        assign rad_in  = rad_r[k-1];
        assign rem_in  = rem_r[k-1];
        assign root_in = root_r[k-1];
        assign side_in = side_r[k-1];
      end

      // bring down the next pair of radicand bits
      assign rem_sh   = {rem_in[SQ_REM_W-3:0], rad_in[SQ_RAD_W-1 -: 2]};
      assign trial    = {2'b00, root_in, 2'b01};
      assign fit      = (rem_sh >= trial);
      assign rem_nxt  = fit ? (rem_sh - trial) : rem_sh;
      assign root_nxt = {root_in[SQ_ROOT_W-2:0], fit};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else begin
          vld_r[k] <= v_in;
        end
        rad_r[k]  <= {rad_in[SQ_RAD_W-3:0], 2'b00};
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end
  endgenerate

  assign out_valid = vld_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule
`default_nettype wire

[sv/qtw_cordic_pipe.sv]
// Vectoring CORDIC arctangent, one iteration per pipeline stage.
`default_nettype none
module qtw_cordic_pipe #(
  parameter int STEPS  = qtw_pkg::CORDIC_STEPS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic signed [qtw_pkg::CW-1:0]   in_x,
  input  logic signed [qtw_pkg::CW-1:0]   in_y,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_valid,
  output logic signed [qtw_pkg::ZW-1:0]   out_z,
  output logic [SIDE_W-1:0]               out_side
);
  import qtw_pkg::*;

  logic                 vld_r  [STEPS];
  logic signed [CW-1:0] x_r    [STEPS];
  logic signed [CW-1:0] y_r    [STEPS];
  logic signed [ZW-1:0] z_r    [STEPS];
  logic [SIDE_W-1:0]    side_r [STEPS];

  genvar i;
  generate
    for (i = 0; i < STEPS; i++) begin : g_iter
      logic                 v_in;
      logic signed [CW-1:0] x_in;
      logic signed [CW-1:0] y_in;
      logic signed [ZW-1:0] z_in;
      logic [SIDE_W-1:0]    side_in;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      logic signed [CW-1:0] x_nxt;
      logic signed [CW-1:0] y_nxt;
      logic signed [ZW-1:0] z_nxt;

      if (i == 0) begin : g_first
        assign v_in    = in_valid;
        assign x_in    = in_x;
        assign y_in    = in_y;
        assign z_in    = '0;
        assign side_in = in_side;
      end else begin : g_next
        assign v_in    = vld_r[i-1];
        assign x_in    = x_r[i-1];
        assign y_in    = y_r[i-1];
        assign z_in    = z_r[i-1];
        assign side_in = side_r[i-1];
      end

      assign xs = x_in >>> i;
      assign ys = y_in >>> i;

      // rotate towards the x axis, by the sign of y
      always_comb begin
        if (!y_in[CW-1]) begin
          x_nxt = x_in + ys;
          y_nxt = y_in - xs;
          z_nxt = z_in + atan_q30(i);
        end else begin
          x_nxt = x_in - ys;
          y_nxt = y_in + xs;
          z_nxt = z_in - atan_q30(i);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else begin
          vld_r[i] <= v_in;
        end
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        z_r[i]    <= z_nxt;
        side_r[i] <= side_in;
      end
    end
  endgenerate

  assign out_valid = vld_r[STEPS-1];
  assign out_z     = z_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule
`default_nettype wire

[sv/qtw_div_pipe.sv]
// Pipelined restoring divider for the soft weight, one quotient bit per stage.
`default_nettype none
module qtw_div_pipe #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [qtw_pkg::M_W-1:0]     in_mag,
  input  logic [qtw_pkg::DEN_W-1:0]   in_den,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [qtw_pkg::WQ_W-1:0]    out_quot,
  output logic [SIDE_W-1:0]           out_side
);
  import qtw_pkg::*;

  localparam int NS = DIV_STAGES;

  logic              vld_r  [NS];
  logic [DEN_W-1:0]  rem_r  [NS];
  logic [DEN_W-1:0]  den_r  [NS];
  logic [WQ_W-1:0]   quot_r [NS];
  logic [SIDE_W-1:0] side_r [NS];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      logic              v_in;
      logic [DEN_W-1:0]  den_in;
      logic [SIDE_W-1:0] side_in;
      logic [DEN_W:0]    rem_sh;
      logic              fit;
      logic [DEN_W:0]    diff;
      logic [DEN_W-1:0]  rem_nxt;
      logic [WQ_W-1:0]   quot_nxt;

      if (k == 0) begin : g_first
        // integer bit: magnitude never exceeds the denominator
        assign v_in     = in_valid;
        assign den_in   = in_den;
        assign side_in  = in_side;
        assign rem_sh   = {1'b0, DEN_W'(in_mag)};
        assign fit      = (rem_sh >= {1'b0, den_in});
        assign diff     = rem_sh - {1'b0, den_in};
        assign quot_nxt = {{(WQ_W-1){1'b0}}, fit};
      end else begin : g_next
        assign v_in     = vld_r[k-1];
        assign den_in   = den_r[k-1];
        assign side_in  = side_r[k-1];
        assign rem_sh   = {rem_r[k-1], 1'b0};
        assign fit      = (rem_sh >= {1'b0, den_in});
        assign diff     = rem_sh - {1'b0, den_in};
        assign quot_nxt = {quot_r[k-1][WQ_W-2:0], fit};
      end

      assign rem_nxt = fit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else begin
          vld_r[k] <= v_in;
        end
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_in;
        quot_r[k] <= quot_nxt;
        side_r[k] <= side_in;
      end
    end
  endgenerate

  assign out_valid = vld_r[NS-1];
  assign out_quot  = quot_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule
`default_nettype wire

[sv/quaternion_tilt_weight_unit.sv]
// Top level of the quaternion tilt weight unit: roll, pitch, soft weights and scaled tilts.
//
// Usage:
//   Input: raise start with a quaternion (w, x, y, z, signed Q1.15) on in_quat_*.
//   busy is never raised, so a transfer happens on every clock with start high:
//   one quaternion per cycle is sustained.
//   Output: out_valid strobes for one cycle with roll and pitch (Q3.13), their
//   weights (Q0.16) and scaled tilts (Q8.8, saturated) on out_*.
//   The path from the start edge to the out_valid edge runs through four product/clamp
//   stages, 31 square-root stages, one stage per CORDIC iteration, one
//   finishing stage, 17 divider stages and four weight/product/rounding
//   stages.
//   Results appear strictly in input order; the receiver cannot stall, and
//   the pipeline never needs to hold.
//   Configuration: cfg_valid with cfg_index/cfg_data writes soft_angle (index 0)
//   or tilt_gain (index 1); cfg_ready is always high, other indexes are
//   ignored. Write only while no item is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline and restores
//   soft_angle to 429 and tilt_gain to 3086.
`default_nettype none
module quaternion_tilt_weight_unit #(
  parameter int CORDIC_STEPS = qtw_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [qtw_pkg::Q_W-1:0]     in_quat_w,
  input  logic signed [qtw_pkg::Q_W-1:0]     in_quat_x,
  input  logic signed [qtw_pkg::Q_W-1:0]     in_quat_y,
  input  logic signed [qtw_pkg::Q_W-1:0]     in_quat_z,
  output logic                               out_valid,
  output logic signed [qtw_pkg::ANG_W-1:0]   out_roll_angle,
  output logic signed [qtw_pkg::ANG_W-1:0]   out_pitch_angle,
  output logic [qtw_pkg::WT_W-1:0]           out_roll_weight,
  output logic [qtw_pkg::WT_W-1:0]           out_pitch_weight,
  output logic signed [qtw_pkg::ANG_W-1:0]   out_roll_scaled,
  output logic signed [qtw_pkg::ANG_W-1:0]   out_pitch_scaled,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qtw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qtw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import qtw_pkg::*;

  localparam int WM_W = WT_W + M_W;
  localparam int PG_W = WM_W + GAIN_W;

  function automatic logic [WT_W-1:0] weight_sel(input logic [WQ_W-1:0] q,
                                                 input logic [M_W-1:0] mag);
    logic [WT_W-1:0] w;
    if (mag == '0) begin
      w = '0;
    end else if (q[WQ_W-1]) begin
      w = '1;
    end else begin
      w = q[WT_W-1:0];
    end
    return w;
  endfunction

  // round half away from zero, then saturate with the sign of the angle
  function automatic logic signed [ANG_W-1:0] scale_sat(input logic [PG_W-1:0] pg,
                                                        input logic neg);
    logic [PG_W:0]         biased;
    logic [PG_W-29:0]      p;
    logic signed [ANG_W-1:0] r;
    biased = {1'b0, pg} + ((PG_W+1)'(1) << 28);
    p      = biased[PG_W:29];
    if (neg) begin
      if (p > (PG_W-28)'(32768)) begin
        r = 16'sh8000;
      end else begin
        r = -signed'(p[ANG_W-1:0]);
      end
    end else begin
      if (p > (PG_W-28)'(32767)) begin
        r = 16'sh7fff;
      end else begin
        r = signed'(p[ANG_W-1:0]);
      end
    end
    return r;
  endfunction

  // configuration registers
  logic [SOFT_W-1:0] soft_r;
  logic [GAIN_W-1:0] gain_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_r <= SOFT_ANGLE_RST;
      gain_r <= TILT_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOFT_ANGLE: soft_r <= cfg_data[SOFT_W-1:0];
        REG_TILT_GAIN:  gain_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: quaternion products, Q.30
  logic v1_r;
  logic signed [31:0] pwx_r, pyz_r, pxx_r, pyy_r, pwy_r, pzx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    pwx_r <= in_quat_w * in_quat_x;
    pyz_r <= in_quat_y * in_quat_z;
    pxx_r <= in_quat_x * in_quat_x;
    pyy_r <= in_quat_y * in_quat_y;
    pwy_r <= in_quat_w * in_quat_y;
    pzx_r <= in_quat_z * in_quat_x;
  end

  // stage 2: numerator, denominator and pitch argument; fold and clamp
  logic signed [33:0] n_raw, d_raw, s_raw, n_nxt, d_nxt;
  logic signed [31:0] s_nxt;
  logic [30:0]        sabs_nxt;
  logic v2_r;
  logic signed [33:0] n2_r, d2_r;
  logic signed [31:0] s2_r;
  logic [30:0]        sabs2_r;

  assign n_raw = (34'(pwx_r) + 34'(pyz_r)) <<< 1;
  assign d_raw = 34'sd1073741824 - ((34'(pxx_r) + 34'(pyy_r)) <<< 1);
  assign s_raw = (34'(pwy_r) - 34'(pzx_r)) <<< 1;

  always_comb begin
    if (d_raw[33]) begin
      n_nxt = -n_raw;
      d_nxt = -d_raw;
    end else begin
      n_nxt = n_raw;
      d_nxt = d_raw;
    end
    if (s_raw > 34'sd1073741824) begin
      s_nxt = 32'sd1073741824;
    end else if (s_raw < -34'sd1073741824) begin
      s_nxt = -32'sd1073741824;
    end else begin
      s_nxt = s_raw[31:0];
    end
    sabs_nxt = s_nxt[31] ? 31'(-s_nxt) : s_nxt[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    n2_r    <= n_nxt;
    d2_r    <= d_nxt;
    s2_r    <= s_nxt;
    sabs2_r <= sabs_nxt;
  end

  // stage 3: square of the pitch argument
  logic v3_r;
  logic [SQ_RAD_W-1:0] sq3_r;
  logic signed [33:0]  n3_r, d3_r;
  logic signed [31:0]  s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    sq3_r <= SQ_RAD_W'(sabs2_r) * SQ_RAD_W'(sabs2_r);
    n3_r  <= n2_r;
    d3_r  <= d2_r;
    s3_r  <= s2_r;
  end

  // stage 4: radicand 1 - s^2 in Q.60
  logic v4_r;
  logic [SQ_RAD_W-1:0] rad4_r;
  logic signed [33:0]  n4_r, d4_r;
  logic signed [31:0]  s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    rad4_r <= (SQ_RAD_W'(1) << 60) - sq3_r;
    n4_r   <= n3_r;
    d4_r   <= d3_r;
    s4_r   <= s3_r;
  end

  // square root for the pitch cosine
  sq_side_t             sq_in_side, sq_out_side;
  logic                 sq_vld;
  logic [SQ_ROOT_W-1:0] c_root;

  assign sq_in_side.n = CW'(n4_r);
  assign sq_in_side.d = CW'(d4_r);
  assign sq_in_side.s = CW'(s4_r);

  qtw_sqrt_pipe #(
    .SIDE_W ($bits(sq_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_rad    (rad4_r),
    .in_side   (sq_in_side),
    .out_valid (sq_vld),
    .out_root  (c_root),
    .out_side  (sq_out_side)
  );

  // both CORDICs run side by side
  roll_flag_t  rf_in, rf_out;
  pitch_flag_t pf_in, pf_out;
  logic                 rc_vld, pc_vld;
  logic signed [ZW-1:0] rz, pz;

  assign rf_in.d_zero = (sq_out_side.d == '0);
  assign rf_in.n_neg  = sq_out_side.n[CW-1];
  assign rf_in.n_pos  = !sq_out_side.n[CW-1] && (sq_out_side.n != '0);
  assign pf_in.c_zero = (c_root == '0);
  assign pf_in.s_pos  = !sq_out_side.s[CW-1] && (sq_out_side.s != '0);

  qtw_cordic_pipe #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W ($bits(roll_flag_t))
  ) u_cordic_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_vld),
    .in_x      (sq_out_side.d),
    .in_y      (sq_out_side.n),
    .in_side   (rf_in),
    .out_valid (rc_vld),
    .out_z     (rz),
    .out_side  (rf_out)
  );

  qtw_cordic_pipe #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W ($bits(pitch_flag_t))
  ) u_cordic_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_vld),
    .in_x      (signed'(CW'(c_root))),
    .in_y      (sq_out_side.s),
    .in_side   (pf_in),
    .out_valid (pc_vld),
    .out_z     (pz),
    .out_side  (pf_out)
  );

  // finishing stage: special angles, Q3.13 rounding, weight denominators
  logic signed [ZW-1:0]    r30, p30;
  logic signed [ZW:0]      r_bias, p_bias, r_sh, p_sh;
  logic signed [ANG_W-1:0] roll_nxt, pitch_nxt, pq13;
  logic [M_W-1:0]          mr_nxt, mp_nxt;
  logic vf_r;
  ang_side_t               rs_f_r, ps_f_r;
  logic [DEN_W-1:0]        denr_f_r, denp_f_r;

  always_comb begin
    if (rf_out.d_zero) begin
      if (rf_out.n_pos) begin
        r30 = HALF_PI_Q30;
      end else if (rf_out.n_neg) begin
        r30 = -HALF_PI_Q30;
      end else begin
        r30 = '0;
      end
    end else begin
      r30 = rz;
    end
    if (pf_out.c_zero) begin
      p30 = pf_out.s_pos ? HALF_PI_Q30 : -HALF_PI_Q30;
    end else begin
      p30 = pz;
    end
    r_bias    = (ZW+1)'(r30) + 34'sd65536;
    p_bias    = (ZW+1)'(p30) + 34'sd65536;
    r_sh      = r_bias >>> 17;
    p_sh      = p_bias >>> 17;
    roll_nxt  = r_sh[ANG_W-1:0];
    pq13      = p_sh[ANG_W-1:0];
    pitch_nxt = -pq13;
    mr_nxt    = roll_nxt[ANG_W-1]  ? M_W'(-roll_nxt)  : roll_nxt[M_W-1:0];
    mp_nxt    = pitch_nxt[ANG_W-1] ? M_W'(-pitch_nxt) : pitch_nxt[M_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else begin
      vf_r <= rc_vld && pc_vld;
    end
    rs_f_r.angle <= roll_nxt;
    rs_f_r.mag   <= mr_nxt;
    ps_f_r.angle <= pitch_nxt;
    ps_f_r.mag   <= mp_nxt;
    denr_f_r     <= DEN_W'(soft_r) + DEN_W'(mr_nxt);
    denp_f_r     <= DEN_W'(soft_r) + DEN_W'(mp_nxt);
  end

  // weight division
  logic            rd_vld, pd_vld;
  logic [WQ_W-1:0] rq, pq;
  ang_side_t       rs_d, ps_d;

  qtw_div_pipe #(
    .SIDE_W ($bits(ang_side_t))
  ) u_div_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vf_r),
    .in_mag    (rs_f_r.mag),
    .in_den    (denr_f_r),
    .in_side   (rs_f_r),
    .out_valid (rd_vld),
    .out_quot  (rq),
    .out_side  (rs_d)
  );

  qtw_div_pipe #(
    .SIDE_W ($bits(ang_side_t))
  ) u_div_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vf_r),
    .in_mag    (ps_f_r.mag),
    .in_den    (denp_f_r),
    .in_side   (ps_f_r),
    .out_valid (pd_vld),
    .out_quot  (pq),
    .out_side  (ps_d)
  );

  // weight, then weight*magnitude, then times gain
  logic vw_r, vp1_r, vp2_r;
  logic [WT_W-1:0]         rw_r, pw_r, rw1_r, pw1_r, rw2_r, pw2_r;
  ang_side_t               rs_w_r, ps_w_r;
  logic signed [ANG_W-1:0] ra1_r, pa1_r, ra2_r, pa2_r;
  logic [WM_W-1:0]         rwm_r, pwm_r;
  logic [PG_W-1:0]         rpg_r, ppg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r  <= 1'b0;
      vp1_r <= 1'b0;
      vp2_r <= 1'b0;
    end else begin
      vw_r  <= rd_vld && pd_vld;
      vp1_r <= vw_r;
      vp2_r <= vp1_r;
    end
    rw_r   <= weight_sel(rq, rs_d.mag);
    pw_r   <= weight_sel(pq, ps_d.mag);
    rs_w_r <= rs_d;
    ps_w_r <= ps_d;

    rwm_r  <= WM_W'(rw_r) * WM_W'(rs_w_r.mag);
    pwm_r  <= WM_W'(pw_r) * WM_W'(ps_w_r.mag);
    rw1_r  <= rw_r;
    pw1_r  <= pw_r;
    ra1_r  <= rs_w_r.angle;
    pa1_r  <= ps_w_r.angle;

    rpg_r  <= PG_W'(rwm_r) * PG_W'(gain_r);
    ppg_r  <= PG_W'(pwm_r) * PG_W'(gain_r);
    rw2_r  <= rw1_r;
    pw2_r  <= pw1_r;
    ra2_r  <= ra1_r;
    pa2_r  <= pa1_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vp2_r;
    end
    out_roll_angle   <= ra2_r;
    out_pitch_angle  <= pa2_r;
    out_roll_weight  <= rw2_r;
    out_pitch_weight <= pw2_r;
    out_roll_scaled  <= scale_sat(rpg_r, ra2_r[ANG_W-1]);
    out_pitch_scaled <= scale_sat(ppg_r, pa2_r[ANG_W-1]);
  end

endmodule
`default_nettype wire

[sv/qtw_checker.sv]
// Port-level checker for the tilt weight unit, bound to the top level.
`default_nettype none
module qtw_checker #(
  parameter int CORDIC_STEPS = qtw_pkg::CORDIC_STEPS_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic signed [qtw_pkg::Q_W-1:0]     in_quat_w,
  input logic signed [qtw_pkg::Q_W-1:0]     in_quat_x,
  input logic signed [qtw_pkg::Q_W-1:0]     in_quat_y,
  input logic signed [qtw_pkg::Q_W-1:0]     in_quat_z,
  input logic                               out_valid,
  input logic signed [qtw_pkg::ANG_W-1:0]   out_roll_angle,
  input logic signed [qtw_pkg::ANG_W-1:0]   out_pitch_angle,
  input logic [qtw_pkg::WT_W-1:0]           out_roll_weight,
  input logic [qtw_pkg::WT_W-1:0]           out_pitch_weight,
  input logic signed [qtw_pkg::ANG_W-1:0]   out_roll_scaled,
  input logic signed [qtw_pkg::ANG_W-1:0]   out_pitch_scaled,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [qtw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input logic [qtw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import qtw_pkg::*;

  localparam int LAT = qtw_latency(CORDIC_STEPS);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe straight after reset");

  a_every_transfer_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted quaternion produced no result at the expected latency");

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching input transfer");

  a_zero_roll_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_roll_angle == '0) |-> (out_roll_weight == '0 && out_roll_scaled == '0))
    else $error("zero roll with nonzero weight or scaled tilt");

  a_pitch_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pitch_angle[ANG_W-1]) |-> !out_pitch_scaled[ANG_W-1])
    else $error("scaled pitch sign disagrees with pitch");

endmodule

bind quaternion_tilt_weight_unit qtw_checker #(
  .CORDIC_STEPS (CORDIC_STEPS)
) u_qtw_checker (.*);
`default_nettype wire
